### rtl/core/mss_pkg.sv
package mss_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 20;
    localparam int SUM_W      = 36;
    localparam int SUMSQ_W    = 51;
    localparam int WORK_W     = 72;
    localparam int MULT_W     = 36;
    localparam int REM_W      = COUNT_W;
    localparam int STD_W      = 15;
    localparam int SPREAD_W   = 16;
    localparam int ROOT_W     = 32;
    localparam int STEP_W     = 7;

    localparam int DIV_STEPS  = 72;
    localparam int MUL_STEPS  = 36;
    localparam int SQRT_STEPS = 16;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

    localparam logic [ROOT_W-1:0] SQRT_BIT_INIT = ROOT_W'(1) << (ROOT_W - 2);

    localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(1048575);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_RESULT = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_AVG   = 3'd1,
        ST_MUL_A = 3'd2,
        ST_MUL_B = 3'd3,
        ST_DIV1  = 3'd4,
        ST_DIV2  = 3'd5,
        ST_SQRT  = 3'd6,
        ST_DONE  = 3'd7
    } t_bstate;

    typedef struct packed {
        t_op                         op;
        t_mode                       mode;
        logic                        page;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        valid;
    } t_cmd;

    typedef struct packed {
        t_mode                       mode;
        logic                        page;
        logic [COUNT_W-1:0]          count;
        logic signed [SAMPLE_W-1:0]  min_val;
        logic signed [SAMPLE_W-1:0]  max_val;
        logic signed [SAMPLE_W-1:0]  average;
        logic                        avg_valid;
        logic [STD_W-1:0]            std_dev;
        logic [SPREAD_W-1:0]         spread;
    } t_result;

endpackage

### rtl/core/mss_front.sv
module mss_front import mss_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_q_full,
    input  logic signed [SAMPLE_W-1:0]  i_sample_value,
    input  logic                        i_sample_valid,
    input  logic                        i_start_stop_event,
    input  logic                        i_page_event,
    output logic                        o_q_push,
    output t_cmd                        o_cmd
);

    t_mode r_mode;
    t_mode n_mode;
    logic  r_page;
    logic  n_page;
    t_op   w_op;
    logic  w_accept;

    assign w_accept = i_push && !i_q_full;
    assign o_q_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_page <= 1'b0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_page <= n_page;
        end
    end

    // start/stop acts first, then the page event in result mode
    always_comb begin
        n_mode = r_mode;
        n_page = r_page;
        w_op   = OP_TICK;
        case (r_mode)
            MODE_RUN: begin
                if (i_start_stop_event) begin
                    n_mode = MODE_RESULT;
                    n_page = 1'b0;
                    w_op   = OP_STOP;
                end
            end
            MODE_RESULT: begin
                if (i_start_stop_event) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                if (i_start_stop_event) begin
                    n_mode = MODE_RUN;
                    w_op   = OP_START;
                end
            end
        endcase
        if (i_page_event && n_mode == MODE_RESULT) begin
            n_page = ~n_page;
        end
        o_cmd.op     = w_op;
        o_cmd.mode   = n_mode;
        o_cmd.page   = n_page;
        o_cmd.sample = i_sample_value;
        o_cmd.valid  = i_sample_valid;
    end

endmodule

### rtl/core/mss_cmd_queue.sv
module mss_cmd_queue import mss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  w_wr;
    logic                  w_rd;

    localparam logic [CMDQ_PTR_W-1:0] PTR_LAST = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
    localparam logic [CMDQ_CNT_W-1:0] CNT_FULL = CMDQ_CNT_W'(CMDQ_DEPTH);

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("command queue count lost a write");

endmodule

### rtl/core/mss_back.sv
module mss_back import mss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_cmd    i_cmd,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_res_valid,
    output t_result o_res
);

    t_bstate                    r_state;
    t_bstate                    n_state;
    logic [COUNT_W-1:0]         r_count;
    logic [COUNT_W-1:0]         n_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic [SUMSQ_W-1:0]         r_sumsq;
    logic [SUMSQ_W-1:0]         n_sumsq;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] n_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic signed [SAMPLE_W-1:0] n_max;
    logic signed [SAMPLE_W-1:0] r_avg;
    logic signed [SAMPLE_W-1:0] n_avg;
    logic                       r_avg_valid;
    logic                       n_avg_valid;
    logic [STD_W-1:0]           r_std;
    logic [STD_W-1:0]           n_std;
    logic [SPREAD_W-1:0]        r_spread;
    logic [SPREAD_W-1:0]        n_spread;
    logic                       r_out_valid;
    logic                       n_out_valid;
    t_result                    r_out;
    t_result                    n_out;

    t_cmd                       r_cmd;
    t_cmd                       n_cmd;
    logic [WORK_W-1:0]          r_work;
    logic [WORK_W-1:0]          n_work;
    logic [REM_W-1:0]           r_rem;
    logic [REM_W-1:0]           n_rem;
    logic [MULT_W-1:0]          r_mult;
    logic [MULT_W-1:0]          n_mult;
    logic signed [WORK_W-1:0]   r_acc;
    logic signed [WORK_W-1:0]   n_acc;
    logic [STEP_W-1:0]          r_step;
    logic [STEP_W-1:0]          n_step;

    t_cmd                       w_cmd;
    logic                       w_out_free;
    logic                       w_out_we;
    logic [MULT_W-1:0]          w_mag;
    logic [REM_W:0]             w_div_sh;
    logic                       w_div_ge;
    logic [REM_W-1:0]           w_div_rem_nx;
    logic [WORK_W-1:0]          w_div_work_nx;
    logic [WORK_W-1:0]          w_addend;
    logic signed [WORK_W-1:0]   w_acc_sub;
    logic [ROOT_W-1:0]          w_trial;
    logic [ROOT_W-1:0]          w_sq_x_nx;
    logic [ROOT_W-1:0]          w_sq_res_nx;
    logic [SAMPLE_W-1:0]        w_q16;
    logic [COUNT_W-1:0]         w_base_count;
    logic signed [SUM_W-1:0]    w_base_sum;
    logic [SUMSQ_W-1:0]         w_base_sumsq;
    logic signed [SAMPLE_W-1:0] w_base_min;
    logic signed [SAMPLE_W-1:0] w_base_max;
    logic                       w_take;
    logic signed [2*SAMPLE_W-1:0] w_square;

    assign w_out_free  = !r_out_valid || i_pop;
    assign w_cmd       = (r_state == ST_IDLE) ? i_cmd : r_cmd;
    assign w_mag       = r_sum[SUM_W-1] ? MULT_W'(-r_sum) : MULT_W'(r_sum);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // restoring divide by the sample count, one quotient bit per cycle
    assign w_div_sh      = {r_rem, r_work[WORK_W-1]};
    assign w_div_ge      = (w_div_sh >= {1'b0, r_count});
    assign w_div_rem_nx  = w_div_ge ? REM_W'(w_div_sh - {1'b0, r_count})
                                    : w_div_sh[REM_W-1:0];
    assign w_div_work_nx = {r_work[WORK_W-2:0], w_div_ge};

    assign w_addend  = r_mult[0] ? r_work : '0;
    assign w_acc_sub = r_acc - $signed(w_addend);

    // bitwise integer square root: radicand in r_work, root in r_acc, bit in r_mult
    assign w_trial     = r_acc[ROOT_W-1:0] + r_mult[ROOT_W-1:0];
    assign w_sq_x_nx   = (r_work[ROOT_W-1:0] >= w_trial) ? r_work[ROOT_W-1:0] - w_trial
                                                          : r_work[ROOT_W-1:0];
    assign w_sq_res_nx = (r_work[ROOT_W-1:0] >= w_trial)
                         ? (r_acc[ROOT_W-1:0] >> 1) + r_mult[ROOT_W-1:0]
                         : (r_acc[ROOT_W-1:0] >> 1);

    assign w_q16    = w_div_work_nx[SAMPLE_W-1:0];
    assign w_square = i_cmd.sample * i_cmd.sample;

    always_comb begin
        w_base_count = (i_cmd.op == OP_START) ? '0 : r_count;
        w_base_sum   = (i_cmd.op == OP_START) ? '0 : r_sum;
        w_base_sumsq = (i_cmd.op == OP_START) ? '0 : r_sumsq;
        w_base_min   = (i_cmd.op == OP_START) ? '0 : r_min;
        w_base_max   = (i_cmd.op == OP_START) ? '0 : r_max;
        w_take       = (i_cmd.mode == MODE_RUN) && i_cmd.valid
                       && (w_base_count < MAX_SAMPLES);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_sumsq     = r_sumsq;
        n_min       = r_min;
        n_max       = r_max;
        n_avg       = r_avg;
        n_avg_valid = r_avg_valid;
        n_std       = r_std;
        n_spread    = r_spread;
        n_cmd       = r_cmd;
        n_work      = r_work;
        n_rem       = r_rem;
        n_mult      = r_mult;
        n_acc       = r_acc;
        n_step      = r_step;
        w_out_we    = 1'b0;
        o_q_pop     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && w_out_free) begin
                    o_q_pop = 1'b1;
                    if (i_cmd.op == OP_STOP && r_count != '0) begin
                        n_cmd       = i_cmd;
                        n_spread    = SPREAD_W'(r_max - r_min);
                        n_avg_valid = 1'b1;
                        n_work      = WORK_W'(w_mag);
                        n_rem       = '0;
                        n_step      = '0;
                        n_state     = ST_AVG;
                    end else begin
                        w_out_we = 1'b1;
                        if (i_cmd.op == OP_STOP) begin
                            n_avg       = i_cmd.valid ? i_cmd.sample : '0;
                            n_avg_valid = i_cmd.valid;
                            n_spread    = '0;
                            n_std       = '0;
                        end
                        n_count = w_base_count;
                        n_sum   = w_base_sum;
                        n_sumsq = w_base_sumsq;
                        n_min   = w_base_min;
                        n_max   = w_base_max;
                        if (w_take) begin
                            if (w_base_count == '0) begin
                                n_min = i_cmd.sample;
                                n_max = i_cmd.sample;
                            end else begin
                                if (i_cmd.sample > w_base_max) begin
                                    n_max = i_cmd.sample;
                                end
                                if (i_cmd.sample < w_base_min) begin
                                    n_min = i_cmd.sample;
                                end
                            end
                            n_count = w_base_count + 1'b1;
                            n_sum   = w_base_sum + SUM_W'(i_cmd.sample);
                            n_sumsq = w_base_sumsq + SUMSQ_W'($unsigned(w_square));
                        end
                    end
                end
            end
            ST_AVG: begin
                n_work = w_div_work_nx;
                n_rem  = w_div_rem_nx;
                n_step = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    // floor toward minus infinity for a negative sum
                    n_avg   = r_sum[SUM_W-1]
                              ? $signed(~w_q16 + SAMPLE_W'(!(|w_div_rem_nx)))
                              : $signed(w_q16);
                    n_work  = WORK_W'(r_sumsq);
                    n_mult  = MULT_W'(r_count);
                    n_acc   = '0;
                    n_step  = '0;
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                n_acc  = r_acc + $signed(w_addend);
                n_work = r_work << 1;
                n_mult = r_mult >> 1;
                n_step = r_step + 1'b1;
                if (r_step == MUL_LAST) begin
                    n_work  = WORK_W'(w_mag);
                    n_mult  = w_mag;
                    n_step  = '0;
                    n_state = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                n_acc  = w_acc_sub;
                n_work = r_work << 1;
                n_mult = r_mult >> 1;
                n_step = r_step + 1'b1;
                if (r_step == MUL_LAST) begin
                    n_step = '0;
                    if (w_acc_sub[WORK_W-1] || w_acc_sub == '0) begin
                        n_std   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_work  = w_acc_sub;
                        n_rem   = '0;
                        n_state = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                n_work = w_div_work_nx;
                n_rem  = w_div_rem_nx;
                n_step = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                n_work = w_div_work_nx;
                n_rem  = w_div_rem_nx;
                n_step = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_acc   = '0;
                    n_mult  = MULT_W'(SQRT_BIT_INIT);
                    n_step  = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                n_work = WORK_W'(w_sq_x_nx);
                n_acc  = WORK_W'(w_sq_res_nx);
                n_mult = MULT_W'(r_mult[ROOT_W-1:0] >> 2);
                n_step = r_step + 1'b1;
                if (r_step == SQRT_LAST) begin
                    n_std   = w_sq_res_nx[STD_W-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_out_we = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out.mode      = w_cmd.mode;
        n_out.page      = w_cmd.page;
        n_out.count     = n_count;
        n_out.min_val   = (n_count != '0) ? n_min : '0;
        n_out.max_val   = (n_count != '0) ? n_max : '0;
        if (w_cmd.mode == MODE_RESULT) begin
            n_out.average   = n_avg;
            n_out.avg_valid = n_avg_valid;
        end else begin
            n_out.average   = w_cmd.valid ? w_cmd.sample : '0;
            n_out.avg_valid = w_cmd.valid;
        end
        n_out.std_dev   = n_std;
        n_out.spread    = n_spread;

        n_out_valid = w_out_we ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_avg       <= '0;
            r_avg_valid <= 1'b0;
            r_std       <= '0;
            r_spread    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_sumsq     <= n_sumsq;
            r_min       <= n_min;
            r_max       <= n_max;
            r_avg       <= n_avg;
            r_avg_valid <= n_avg_valid;
            r_std       <= n_std;
            r_spread    <= n_spread;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_work <= n_work;
        r_rem  <= n_rem;
        r_mult <= n_mult;
        r_acc  <= n_acc;
        r_step <= n_step;
        if (w_out_we) begin
            r_out <= n_out;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_we |-> (!r_out_valid || i_pop))
        else $error("result register overwritten before it was taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_q_pop)
        else $error("command taken while a stop computation is running");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_SAMPLES)
        else $error("sample count passed its limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("session minimum above maximum");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DONE) |=> $stable(r_count))
        else $error("totals moved during a stop computation");

endmodule

### rtl/core/measurement_session_statistics_top.sv
// Measurement session statistics.
// Input channel: one tick per item (sample, valid flag, start/stop and page
// events), taken at a clock edge with push high and full low. Result channel:
// one result item per tick; it stands on the o_ ports while empty is low and
// is taken at an edge with pop high.
// A normal tick passes through the command queue and then the result register,
// and the block sustains one tick per cycle for such items while each result is
// popped as it appears. The stop tick of a session with samples runs a serial
// mean divide, a shift-add product of count*sum_of_squares - sum^2, two divides
// by the count and a 16-step square root; the divides and the root are skipped
// when the variance is zero. The back end uses a shared divider and a
// bit-serial multiplier for this work.
// A four-entry command queue sits between the event decoder and the
// arithmetic, and the result sits in its own register, so ticks keep being
// taken while the receiver stalls until the queue fills and full rises.
// Reset (synchronous, active low) returns the mode to idle, page to zero and
// clears all totals and latched results; queued ticks are dropped.
module measurement_session_statistics_top import mss_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [SAMPLE_W-1:0]  i_sample_value,
    input  logic                        i_sample_valid,
    input  logic                        i_start_stop_event,
    input  logic                        i_page_event,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_mode,
    output logic                        o_result_page,
    output logic [COUNT_W-1:0]          o_sample_count,
    output logic signed [SAMPLE_W-1:0]  o_running_min,
    output logic signed [SAMPLE_W-1:0]  o_running_max,
    output logic signed [SAMPLE_W-1:0]  o_average,
    output logic                        o_average_valid,
    output logic [STD_W-1:0]            o_std_dev,
    output logic [SPREAD_W-1:0]         o_spread
);

    logic    w_q_push;
    logic    w_q_pop;
    logic    w_q_full;
    logic    w_q_empty;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_head;
    logic    w_res_valid;
    t_result w_res;

    mss_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_q_full           (w_q_full),
        .i_sample_value     (i_sample_value),
        .i_sample_valid     (i_sample_valid),
        .i_start_stop_event (i_start_stop_event),
        .i_page_event       (i_page_event),
        .o_q_push           (w_q_push),
        .o_cmd              (w_cmd_in)
    );

    mss_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_cmd_head)
    );

    mss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_cmd       (w_cmd_head),
        .o_q_pop     (w_q_pop),
        .i_pop       (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign full            = w_q_full;
    assign empty           = !w_res_valid;
    assign o_mode          = w_res.mode;
    assign o_result_page   = w_res.page;
    assign o_sample_count  = w_res.count;
    assign o_running_min   = w_res.min_val;
    assign o_running_max   = w_res.max_val;
    assign o_average       = w_res.average;
    assign o_average_valid = w_res.avg_valid;
    assign o_std_dev       = w_res.std_dev;
    assign o_spread        = w_res.spread;

endmodule
